### src/slt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list table package
// Shared constants, operation codes, sequencer states and the request and
// result records passed between the top level and the list engine.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = 4;
	localparam int CNT_W      = 5;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

	typedef enum logic [2:0] {
		KIND_INSERT = 3'd0,
		KIND_REMOVE = 3'd1,
		KIND_SEARCH = 3'd2,
		KIND_READ   = 3'd3,
		KIND_WRITE  = 3'd4,
		KIND_CLEAR  = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [2:0]            kind;
		logic [ADDR_W-1:0]     position;
		logic [DATA_WIDTH-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  ok;
		logic [ADDR_W-1:0]     found_position;
		logic [DATA_WIDTH-1:0] read_value;
		logic [CNT_W-1:0]      entry_count;
		logic                  is_empty;
		logic                  is_full;
	} res_t;

endpackage

### src/slt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List engine
// Holds the entry memory and the entry count, and runs one request at a time
// as a stream of memory reads and write-backs.
// ----------------------------------------------------------------------------
module slt_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  slt_pkg::req_t            req,
	input  logic [slt_pkg::CNT_W-1:0] cap,
	output logic                     res_valid,
	input  logic                     res_ready,
	output slt_pkg::res_t            res
);
	import slt_pkg::*;

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] mem_rdata_s1;

	state_t                state_q, state_d;
	req_t                  req_q;
	logic                  legal_q;
	logic [CNT_W-1:0]      ptr_q, ptr_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  ok_q, ok_d;
	logic [ADDR_W-1:0]     fpos_q, fpos_d;
	logic [DATA_WIDTH-1:0] rval_q, rval_d;
	logic                  rd_valid_s1;
	logic [ADDR_W-1:0]     rd_addr_s1;

	logic                  accept;
	logic                  legal_d;
	logic                  op_done;
	logic                  rd_issue;
	logic [ADDR_W-1:0]     rd_addr;
	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [CNT_W-1:0]      pos_ext;
	logic [CNT_W-1:0]      limit;

	assign accept    = req_valid && req_ready;
	assign pos_ext   = CNT_W'(req_q.position);
	assign limit     = (kind_t'(req_q.kind) == KIND_READ) ? pos_ext + CNT_W'(1) : count_q;
	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);

	always_comb begin
		res.ok             = ok_q;
		res.found_position = fpos_q;
		res.read_value     = rval_q;
		res.entry_count    = count_q;
		res.is_empty       = (count_q == '0);
		res.is_full        = (count_q >= cap);
	end

	// Bound checks are made once, when the request is taken.
	always_comb begin
		legal_d = 1'b1;
		unique case (kind_t'(req.kind))
			KIND_INSERT: legal_d = (CNT_W'(req.position) <= count_q) && (count_q < cap);
			KIND_REMOVE, KIND_READ, KIND_WRITE: legal_d = (CNT_W'(req.position) < count_q);
			default: legal_d = 1'b1;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid) state_d = ST_RUN;
			ST_RUN:  if (op_done) state_d = ST_RESP;
			ST_RESP: if (res_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory read issue, write-back and result updates.
	always_comb begin
		op_done  = 1'b0;
		rd_issue = 1'b0;
		rd_addr  = '0;
		we       = 1'b0;
		waddr    = '0;
		wdata    = req_q.value;
		ptr_d    = ptr_q;
		count_d  = count_q;
		ok_d     = ok_q;
		fpos_d   = fpos_q;
		rval_d   = rval_q;

		if (state_q == ST_IDLE && accept) begin
			ok_d   = 1'b0;
			fpos_d = '0;
			rval_d = '0;
			unique case (kind_t'(req.kind))
				KIND_INSERT: ptr_d = count_q;
				KIND_SEARCH: ptr_d = '0;
				default:     ptr_d = CNT_W'(req.position);
			endcase
		end else if (state_q == ST_RUN) begin
			unique case (kind_t'(req_q.kind))
				KIND_INSERT: begin
					if (!legal_q) begin
						op_done = 1'b1;
					end else begin
						// Walk down from the top, moving each entry one slot up.
						if (ptr_q > pos_ext) begin
							rd_issue = 1'b1;
							rd_addr  = ADDR_W'(ptr_q - CNT_W'(1));
							ptr_d    = ptr_q - CNT_W'(1);
						end
						if (rd_valid_s1) begin
							we    = 1'b1;
							waddr = rd_addr_s1 + ADDR_W'(1);
							wdata = mem_rdata_s1;
						end else if (ptr_q == pos_ext) begin
							we      = 1'b1;
							waddr   = req_q.position;
							op_done = 1'b1;
							ok_d    = 1'b1;
							count_d = count_q + CNT_W'(1);
						end
					end
				end
				KIND_REMOVE, KIND_READ: begin
					if (!legal_q) begin
						op_done = 1'b1;
					end else begin
						if (ptr_q < limit) begin
							rd_issue = 1'b1;
							rd_addr  = ADDR_W'(ptr_q);
							ptr_d    = ptr_q + CNT_W'(1);
						end
						if (rd_valid_s1) begin
							if (rd_addr_s1 == req_q.position) begin
								rval_d = mem_rdata_s1;
							end else begin
								// Remove only: entries above the hole move one slot down.
								we    = 1'b1;
								waddr = rd_addr_s1 - ADDR_W'(1);
								wdata = mem_rdata_s1;
							end
						end else if (ptr_q >= limit) begin
							op_done = 1'b1;
							ok_d    = 1'b1;
							if (kind_t'(req_q.kind) == KIND_REMOVE) begin
								count_d = count_q - CNT_W'(1);
							end
						end
					end
				end
				KIND_SEARCH: begin
					if (rd_valid_s1 && mem_rdata_s1 == req_q.value) begin
						op_done = 1'b1;
						ok_d    = 1'b1;
						fpos_d  = rd_addr_s1;
					end else if (ptr_q < count_q) begin
						rd_issue = 1'b1;
						rd_addr  = ADDR_W'(ptr_q);
						ptr_d    = ptr_q + CNT_W'(1);
					end else if (!rd_valid_s1) begin
						op_done = 1'b1;
					end
				end
				KIND_WRITE: begin
					we      = legal_q;
					waddr   = req_q.position;
					ok_d    = legal_q;
					op_done = 1'b1;
				end
				KIND_CLEAR: begin
					count_d = '0;
					ok_d    = 1'b1;
					op_done = 1'b1;
				end
				default: op_done = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_valid_s1 <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			legal_q <= legal_d;
		end
		ptr_q      <= ptr_d;
		ok_q       <= ok_d;
		fpos_q     <= fpos_d;
		rval_q     <= rval_d;
		rd_addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_issue) begin
			mem_rdata_s1 <= mem[rd_addr];
		end
	end

	// The list never holds more entries than the store has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_CNT)
		else $error("entry count beyond store depth");

	// Reads only touch live entries, so no unwritten slot is ever returned.
	a_read_live: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |-> (CNT_W'(rd_addr) < count_q))
		else $error("memory read at a slot outside the list");

	// Write-backs stay within the list or the one slot that insert opens.
	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CNT_W'(waddr) <= count_q))
		else $error("memory write beyond the list end");

	// A delivered result returns the engine to idle on the next cycle.
	a_resp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> req_ready)
		else $error("engine did not return to idle after the result");

endmodule

### src/sequential_list_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequential list table unit
// Ordered list of 32-bit entries with insert, remove, search, read, write and
// clear requests, one status result per request.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream group; each transfer carries one operation
// code in s_tuser and a position and value in s_tdata. Every request yields
// exactly one result transfer on the m_ stream group, in request order.
// The capacity register is loaded through cfg_wen/cfg_wdata; the user must
// load it only while the unit is idle, which the unit does not enforce.
// Values above the store depth act as the full depth. Requests are handled
// one at a time. Insert and remove walk the entries between the position and
// the list end, and search walks the list from the start until a match or
// the list end; clear, write and read need no walk. The walk runs on the
// single read port of the entry memory, which the sequencer steps through
// one entry per cycle.
// Reset clears the entry count and loads the capacity with 16; the entry
// memory keeps whatever it holds and is only read below the entry count.
// A finished result sits in the output register, so the next request can be
// taken while it waits. If the receiver stalls longer, the engine holds its
// next result and stops taking requests until the register frees up.
// ----------------------------------------------------------------------------
module sequential_list_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[3:0], value[35:4], zero[39:36]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // ok[0], found_position[4:1], read_value[36:5],
	                               // entry_count[41:37], is_empty[42], is_full[43],
	                               // zero[47:44]
	// Capacity register.
	input  logic        cfg_wen,
	input  logic [4:0]  cfg_wdata
);
	import slt_pkg::*;

	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] cap_eff;
	req_t             req;
	res_t             res;
	logic             res_valid;
	logic             res_ready;
	logic             m_tvalid_q;
	logic [47:0]      m_tdata_q;

	// The capacity register; any written value is kept, and the engine sees it
	// limited to the store depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wen) begin
			cap_q <= cfg_wdata;
		end
	end

	assign cap_eff = (cap_q > DEPTH_CNT) ? DEPTH_CNT : cap_q;

	always_comb begin
		req.kind     = s_tuser;
		req.position = s_tdata[3:0];
		req.value    = s_tdata[35:4];
	end

	slt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.cap       (cap_eff),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: loads a new result whenever it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {4'b0000, res.is_full, res.is_empty, res.entry_count,
				res.read_value, res.found_position, res.ok};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
